FILE: src/bsc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsc_pkg: barometric compensation shared types and microcode
// Payload structs, datapath widths, control word layout and the program rom.
// ---------------------------------------------------------------------------
package bsc_pkg;

   // field widths
   localparam int unsigned RAW_W   = 24;
   localparam int unsigned VALUE_W = 24;
   localparam int unsigned COEFF_W = 16;
   localparam int unsigned CSR_IDX_W = 3;

   // datapath widths
   localparam int unsigned DT_W    = 25;   // raw minus tref*256
   localparam int unsigned MB_W    = 17;   // coefficient or sens chunk, signed
   localparam int unsigned PROD_W  = DT_W + MB_W;
   localparam int unsigned OFF_W   = 36;
   localparam int unsigned SENS_W  = 36;
   localparam int unsigned ACC_W   = 61;   // holds raw*sens with margin
   localparam int unsigned CHUNK_W = 16;

   // scheme constants
   localparam int unsigned TREF_SHIFT      = 8;
   localparam int unsigned OFF_BASE_SHIFT  = 17;
   localparam int unsigned SENS_BASE_SHIFT = 16;
   localparam int          TEMP_BASE       = 2000;
   localparam int          VALUE_MAX       = 8388607;
   localparam int          VALUE_MIN       = -8388608;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS     = 3'd0,
      CSR_OFF      = 3'd1,
      CSR_TCS      = 3'd2,
      CSR_TCO      = 3'd3,
      CSR_TREF     = 3'd4,
      CSR_TEMPSENS = 3'd5
   } csr_index_type;

   // conversion kinds
   localparam logic OP_TEMP  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   typedef struct packed {
      logic             op;
      logic [RAW_W-1:0] raw;
   } req_payload_type;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
   } rsp_payload_type;

   // control word fields
   typedef enum logic [0:0] {
      MA_DT  = 1'b0,
      MA_RAW = 1'b1
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      MB_TEMPSENS = 3'd0,
      MB_TCO      = 3'd1,
      MB_TCS      = 3'd2,
      MB_SENS_LO  = 3'd3,
      MB_SENS_MID = 3'd4,
      MB_SENS_HI  = 3'd5
   } mul_b_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD      = 3'd0,
      ACC_PROD_SHR  = 3'd1,
      ACC_SELF_SHR  = 3'd2,
      ACC_ADD_TEMP  = 3'd3,
      ACC_ADD_OFFB  = 3'd4,
      ACC_ADD_SENSB = 3'd5,
      ACC_MAC16     = 3'd6,
      ACC_SUB_OFF   = 3'd7
   } acc_op_type;

   typedef enum logic [2:0] {
      SH_0  = 3'd0,
      SH_6  = 3'd1,
      SH_7  = 3'd2,
      SH_15 = 3'd3,
      SH_21 = 3'd4,
      SH_23 = 3'd5
   } shift_sel_type;

   typedef enum logic [1:0] {
      COND_NEXT  = 2'd0,
      COND_PRESS = 2'd1,   // jump to target on a pressure item
      COND_EMIT  = 2'd2    // hand off the result, hold while output is full
   } cond_type;

   localparam int unsigned STEP_W = 5;

   // program labels
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 5'd0;
   localparam logic [STEP_W-1:0] STEP_PRESS    = 5'd6;

   typedef struct packed {
      mul_a_sel_type     mul_a;
      mul_b_sel_type     mul_b;
      logic              mul_en;
      acc_op_type        acc_op;
      shift_sel_type     shift;
      logic              dt_we;
      logic              off_we;
      logic              sens_we;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      mul_a:   MA_DT,
      mul_b:   MB_TEMPSENS,
      mul_en:  1'b0,
      acc_op:  ACC_HOLD,
      shift:   SH_0,
      dt_we:   1'b0,
      off_we:  1'b0,
      sens_we: 1'b0,
      cond:    COND_NEXT,
      target:  STEP_DISPATCH
   };

   // program rom
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = UC_NOP;
      unique case (step)
         // dispatch on conversion kind
         5'd0: begin
            w.cond   = COND_PRESS;
            w.target = STEP_PRESS;
         end
         // temperature: dt, dt*c6, /2^23, +2000
         5'd1: w.dt_we = 1'b1;
         5'd2: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_DT;
            w.mul_b  = MB_TEMPSENS;
         end
         5'd3: begin
            w.acc_op = ACC_PROD_SHR;
            w.shift  = SH_23;
         end
         5'd4: w.acc_op = ACC_ADD_TEMP;
         5'd5: w.cond   = COND_EMIT;
         // pressure: off
         5'd6: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_DT;
            w.mul_b  = MB_TCO;
         end
         5'd7: begin
            w.acc_op = ACC_PROD_SHR;
            w.shift  = SH_6;
         end
         5'd8: w.acc_op = ACC_ADD_OFFB;
         // sens
         5'd9: begin
            w.off_we = 1'b1;
            w.mul_en = 1'b1;
            w.mul_a  = MA_DT;
            w.mul_b  = MB_TCS;
         end
         5'd10: begin
            w.acc_op = ACC_PROD_SHR;
            w.shift  = SH_7;
         end
         5'd11: w.acc_op  = ACC_ADD_SENSB;
         5'd12: w.sens_we = 1'b1;
         // raw*sens in two 16-bit chunks and a 4-bit top chunk, top chunk first
         5'd13: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_RAW;
            w.mul_b  = MB_SENS_HI;
         end
         5'd14: begin
            w.acc_op = ACC_PROD_SHR;
            w.shift  = SH_0;
            w.mul_en = 1'b1;
            w.mul_a  = MA_RAW;
            w.mul_b  = MB_SENS_MID;
         end
         5'd15: begin
            w.acc_op = ACC_MAC16;
            w.mul_en = 1'b1;
            w.mul_a  = MA_RAW;
            w.mul_b  = MB_SENS_LO;
         end
         5'd16: w.acc_op = ACC_MAC16;
         5'd17: begin
            w.acc_op = ACC_SELF_SHR;
            w.shift  = SH_21;
         end
         5'd18: w.acc_op = ACC_SUB_OFF;
         5'd19: begin
            w.acc_op = ACC_SELF_SHR;
            w.shift  = SH_15;
         end
         5'd20: w.cond = COND_EMIT;
         default: w.cond = COND_EMIT;
      endcase
      return w;
   endfunction

   // arithmetic shift right that rounds toward zero
   function automatic logic signed [ACC_W-1:0] trunc_by(
      input logic signed [ACC_W-1:0] a,
      input int unsigned             n
   );
      logic signed [ACC_W-1:0] bias;
      logic signed [ACC_W-1:0] sum;
      bias = a[ACC_W-1] ? $signed((ACC_W'(1) << n) - ACC_W'(1)) : '0;
      sum  = a + bias;
      return sum >>> n;
   endfunction

   function automatic logic signed [ACC_W-1:0] shr_trunc(
      input logic signed [ACC_W-1:0] a,
      input shift_sel_type           sh
   );
      logic signed [ACC_W-1:0] r;
      unique case (sh)
         SH_0:    r = a;
         SH_6:    r = trunc_by(a, 6);
         SH_7:    r = trunc_by(a, 7);
         SH_15:   r = trunc_by(a, 15);
         SH_21:   r = trunc_by(a, 21);
         SH_23:   r = trunc_by(a, 23);
         default: r = a;
      endcase
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] sat24(
      input logic signed [ACC_W-1:0] a
   );
      logic signed [VALUE_W-1:0] r;
      if (a > $signed(ACC_W'(VALUE_MAX))) begin
         r = VALUE_W'(VALUE_MAX);
      end else if (a < $signed(ACC_W'(VALUE_MIN))) begin
         r = VALUE_W'(VALUE_MIN);
      end else begin
         r = a[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/baro_sensor_compensation_top.sv
`timescale 1ns / 1ps
// flow: one item at a time; the next transfer is taken the cycle after the result is
// registered, and no new item is accepted while the current one is still in progress
// each item steps through the microprogram on the single shared 25x17 multiplier
// reset: synchronous, active high; clears coefficients, stored dT and all control state
// ---------------------------------------------------------------------------
// baro_sensor_compensation_top: first-order barometric compensation
// Microcoded sequencer: a rom of control words steps a small datapath made
// of one signed multiplier, a product register and a wide accumulator.
// ---------------------------------------------------------------------------
module baro_sensor_compensation_top (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bsc_pkg::req_payload_type          req_payload,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bsc_pkg::rsp_payload_type          rsp_payload,
   // coefficient write port
   input  logic                              csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsc_pkg::COEFF_W-1:0]       csr_wdata
);
   import bsc_pkg::*;

   // calibration coefficients
   logic [COEFF_W-1:0] coeff_sens_ff;
   logic [COEFF_W-1:0] coeff_off_ff;
   logic [COEFF_W-1:0] coeff_tcs_ff;
   logic [COEFF_W-1:0] coeff_tco_ff;
   logic [COEFF_W-1:0] coeff_tref_ff;
   logic [COEFF_W-1:0] coeff_tempsens_ff;

   // sequencer
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;

   // latched item
   logic             op_ff;
   logic [RAW_W-1:0] raw_ff;

   // datapath
   logic signed [DT_W-1:0]   dt_ff, dt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [OFF_W-1:0]  off_ff;
   logic signed [SENS_W-1:0] sens_ff;
   logic signed [DT_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   logic            out_free;
   logic            emit;
   logic            req_xfer;

   // coefficient writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_sens_ff     <= '0;
         coeff_off_ff      <= '0;
         coeff_tcs_ff      <= '0;
         coeff_tco_ff      <= '0;
         coeff_tref_ff     <= '0;
         coeff_tempsens_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SENS:     coeff_sens_ff     <= csr_wdata;
            CSR_OFF:      coeff_off_ff      <= csr_wdata;
            CSR_TCS:      coeff_tcs_ff      <= csr_wdata;
            CSR_TCO:      coeff_tco_ff      <= csr_wdata;
            CSR_TREF:     coeff_tref_ff     <= csr_wdata;
            CSR_TEMPSENS: coeff_tempsens_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input side: one item in flight, taken only while the sequencer rests
   assign req_stall = busy_ff;
   assign req_xfer  = req_valid && !busy_ff;

   // current control word
   assign uc = ucode_rom(step_ff);

   // output register is free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy_ff && (uc.cond == COND_EMIT) && out_free;

   // step counter and branch logic
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (req_xfer) begin
            busy_in = 1'b1;
            step_in = STEP_DISPATCH;
         end
      end else begin
         unique case (uc.cond)
            COND_NEXT:  step_in = step_ff + STEP_W'(1);
            COND_PRESS: step_in = (op_ff == OP_PRESS) ? uc.target : step_ff + STEP_W'(1);
            COND_EMIT: begin
               // hold on this step until the result register frees up
               if (out_free) begin
                  busy_in = 1'b0;
                  step_in = STEP_DISPATCH;
               end
            end
            default:    step_in = step_ff + STEP_W'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_DISPATCH;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= req_payload.op;
         raw_ff <= req_payload.raw;
      end
   end

   // dT = D2 - C5*256, kept across items
   assign dt_in = $signed({1'b0, raw_ff}) - $signed({1'b0, coeff_tref_ff, TREF_SHIFT'(0)});

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= '0;
      end else if (busy_ff && uc.dt_we) begin
         dt_ff <= dt_in;
      end
   end

   // multiplier operands; sens is fed as two unsigned chunks and a signed top
   always_comb begin
      unique case (uc.mul_a)
         MA_DT:   mul_a = dt_ff;
         MA_RAW:  mul_a = $signed({1'b0, raw_ff});
         default: mul_a = dt_ff;
      endcase
   end

   always_comb begin
      unique case (uc.mul_b)
         MB_TEMPSENS: mul_b = $signed({1'b0, coeff_tempsens_ff});
         MB_TCO:      mul_b = $signed({1'b0, coeff_tco_ff});
         MB_TCS:      mul_b = $signed({1'b0, coeff_tcs_ff});
         MB_SENS_LO:  mul_b = $signed({1'b0, sens_ff[CHUNK_W-1:0]});
         MB_SENS_MID: mul_b = $signed({1'b0, sens_ff[2*CHUNK_W-1:CHUNK_W]});
         MB_SENS_HI:  mul_b = $signed({{(MB_W-(SENS_W-2*CHUNK_W)){sens_ff[SENS_W-1]}},
                                       sens_ff[SENS_W-1:2*CHUNK_W]});
         default:     mul_b = $signed({1'b0, coeff_tempsens_ff});
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (busy_ff && uc.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // accumulator operations, all divisions round toward zero
   always_comb begin
      unique case (uc.acc_op)
         ACC_HOLD:      acc_in = acc_ff;
         ACC_PROD_SHR:  acc_in = shr_trunc(ACC_W'(prod_ff), uc.shift);
         ACC_SELF_SHR:  acc_in = shr_trunc(acc_ff, uc.shift);
         ACC_ADD_TEMP:  acc_in = acc_ff + $signed(ACC_W'(TEMP_BASE));
         ACC_ADD_OFFB:  acc_in = acc_ff + $signed(ACC_W'(coeff_off_ff) << OFF_BASE_SHIFT);
         ACC_ADD_SENSB: acc_in = acc_ff + $signed(ACC_W'(coeff_sens_ff) << SENS_BASE_SHIFT);
         ACC_MAC16:     acc_in = (acc_ff <<< CHUNK_W) + ACC_W'(prod_ff);
         ACC_SUB_OFF:   acc_in = acc_ff - ACC_W'(off_ff);
         default:       acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

   // OFF and SENS snapshots for the pressure tail
   always_ff @(posedge clock) begin
      if (busy_ff && uc.off_we) begin
         off_ff <= acc_ff[OFF_W-1:0];
      end
      if (busy_ff && uc.sens_we) begin
         sens_ff <= acc_ff[SENS_W-1:0];
      end
   end

   // result register, saturated to 24 bits
   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff.kind  <= op_ff;
         rsp_payload_ff.value <= sat24(acc_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: tb/baro_sensor_compensation_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// baro_sensor_compensation_top_tb: self-checking regression for compensation
// Sends temperature and pressure conversions under random idling and long
// result back-pressure. An independent 64-bit integer model predicts every
// result, and each result transfer is checked field by field.
// ---------------------------------------------------------------------------
module baro_sensor_compensation_top_tb;
   import bsc_pkg::*;

   localparam int unsigned CLK_HALF_NS     = 6;
   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned SETTLE_CYCLES   = 30;      // beyond a pressure conversion
   localparam int unsigned DRAIN_LIMIT     = 50000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam longint      RUN_LIMIT_NS    = 4_000_000;
   localparam int          NUM_COEFFS      = 6;
   localparam longint      TEMP_OFFSET     = 2000;    // 20.00 degC

   // indexes past the last coefficient, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [RAW_W-1:0]   RAW_MAX   = '1;
   localparam logic [COEFF_W-1:0] COEFF_MAX = '1;

   // every block input starts known
   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [COEFF_W-1:0]   csr_wdata   = '0;

   // idling knobs, in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // receiver hold-off, counted down by the stall process
   int rsp_hold_left = 0;
   int failures      = 0;

   // shadow of the block's coefficients and kept dT
   logic [COEFF_W-1:0]     coeff_shadow [NUM_COEFFS] = '{default: '0};
   logic signed [DT_W-1:0] kept_delta = '0;

   // results still owed by the block, oldest first
   rsp_payload_type pending_results [$];

   baro_sensor_compensation_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   function automatic longint pow2(input int n);
      return longint'(1) << n;
   endfunction

   // first-order compensation, exact integers, divisions truncate toward zero
   function automatic rsp_payload_type compensate(input logic op, input logic [RAW_W-1:0] raw);
      longint c_sens, c_off, c_tcs, c_tco, c_tref, c_tsens;
      longint d_raw, delta, offset, sensitivity, scaled, acc;
      rsp_payload_type r;
      c_sens  = longint'(coeff_shadow[CSR_SENS]);
      c_off   = longint'(coeff_shadow[CSR_OFF]);
      c_tcs   = longint'(coeff_shadow[CSR_TCS]);
      c_tco   = longint'(coeff_shadow[CSR_TCO]);
      c_tref  = longint'(coeff_shadow[CSR_TREF]);
      c_tsens = longint'(coeff_shadow[CSR_TEMPSENS]);
      d_raw   = longint'(raw);
      if (op == OP_TEMP) begin
         delta      = d_raw - c_tref * pow2(8);
         kept_delta = delta[DT_W-1:0];
         acc        = TEMP_OFFSET + (delta * c_tsens) / pow2(23);
      end else begin
         // pressure uses whatever dT the last temperature left behind
         delta       = longint'(kept_delta);
         offset      = c_off * pow2(17) + (c_tco * delta) / pow2(6);
         sensitivity = c_sens * pow2(16) + (c_tcs * delta) / pow2(7);
         scaled      = (d_raw * sensitivity) / pow2(21);
         acc         = (scaled - offset) / pow2(15);
      end
      if (acc > VALUE_MAX) acc = VALUE_MAX;
      if (acc < VALUE_MIN) acc = VALUE_MIN;
      r.kind  = op;
      r.value = acc[VALUE_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // random values
   // ------------------------------------------------------------------------

   function automatic logic [COEFF_W-1:0] rand_coeff();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return COEFF_MAX;
         default: return COEFF_W'($urandom());
      endcase
   endfunction

   // half full range, some extremes, some near the reference temperature
   function automatic logic [RAW_W-1:0] rand_raw();
      longint centre;
      centre = longint'(coeff_shadow[CSR_TREF]) * 256
             + longint'($urandom_range(0, 131072)) - 65536;
      if (centre < 0) centre = 0;
      if (centre > longint'(RAW_MAX)) centre = longint'(RAW_MAX);
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return RAW_MAX;
         2, 3, 4:    return centre[RAW_W-1:0];
         default:    return RAW_W'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // one write per edge, enable left high so back-to-back writes never toggle it
   task automatic write_coeff(input logic [CSR_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx < NUM_COEFFS) coeff_shadow[idx] = val;
   endtask

   task automatic load_coeffs(input logic [COEFF_W-1:0] c_sens, c_off, c_tcs,
                              input logic [COEFF_W-1:0] c_tco, c_tref, c_tsens);
      write_coeff(CSR_SENS, c_sens);
      write_coeff(CSR_OFF, c_off);
      write_coeff(CSR_TCS, c_tcs);
      write_coeff(CSR_TCO, c_tco);
      write_coeff(CSR_TREF, c_tref);
      write_coeff(CSR_TEMPSENS, c_tsens);
      csr_we <= 1'b0;
   endtask

   task automatic load_random_coeffs();
      load_coeffs(rand_coeff(), rand_coeff(), rand_coeff(),
                  rand_coeff(), rand_coeff(), rand_coeff());
   endtask

   // offer one conversion, return at the edge that takes the transfer;
   // valid stays high so the next call can follow without a bubble
   task automatic send_conversion(input logic op, input logic [RAW_W-1:0] raw);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{op: op, raw: raw};
      do @(posedge clock); while (req_stall);
      pending_results.push_back(compensate(op, raw));
   endtask

   // sender pause: nothing offered until every owed result is back,
   // then let the sequencer settle before any coefficient write
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // receiver and checker
   // ------------------------------------------------------------------------

   // random stall, or a forced hold-off when one is requested
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // every result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing pending: kind %0d value %0d",
                   rsp_payload.kind, $signed(rsp_payload.value));
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.kind !== want.kind) begin
               $error("kind mismatch: expected %0d actual %0d", want.kind, rsp_payload.kind);
               failures++;
            end
            if (rsp_payload.value !== want.value) begin
               $error("value mismatch: expected %0d actual %0d",
                      $signed(want.value), $signed(rsp_payload.value));
               failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // coefficients and dT straight out of reset, pressure before any temperature
   task automatic test_pressure_before_temp();
      send_conversion(OP_PRESS, RAW_MAX);
      wait_drained();
      load_coeffs(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
      send_conversion(OP_PRESS, RAW_MAX);
      send_conversion(OP_PRESS, 24'd6465444);
      send_conversion(OP_TEMP, 24'd8077636);
      send_conversion(OP_PRESS, 24'd6465444);
      wait_drained();
   endtask

   // largest and smallest dT against saturated and empty coefficient sets
   task automatic test_coeff_extremes();
      load_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
      send_conversion(OP_TEMP, '0);
      send_conversion(OP_PRESS, '0);
      send_conversion(OP_PRESS, RAW_MAX);
      send_conversion(OP_TEMP, RAW_MAX);
      send_conversion(OP_PRESS, '0);
      send_conversion(OP_PRESS, RAW_MAX);
      wait_drained();
      // negative sensitivity, most negative pressure
      load_coeffs('0, COEFF_MAX, COEFF_MAX, '0, COEFF_MAX, COEFF_MAX);
      send_conversion(OP_TEMP, '0);
      send_conversion(OP_PRESS, RAW_MAX);
      send_conversion(OP_PRESS, '0);
      wait_drained();
      load_coeffs('0, '0, '0, '0, '0, '0);
      send_conversion(OP_TEMP, RAW_MAX);
      send_conversion(OP_PRESS, RAW_MAX);
      wait_drained();
   endtask

   // writes past the last coefficient must not land anywhere
   task automatic test_unused_index();
      write_coeff(CSR_SPARE_LO, COEFF_MAX);
      write_coeff(CSR_SPARE_HI, 16'hA5A5);
      csr_we <= 1'b0;
      send_conversion(OP_TEMP, 24'h5A5A5A);
      send_conversion(OP_PRESS, RAW_MAX);
      wait_drained();
   endtask

   // long receiver hold-off while the sender keeps offering, block backs up
   task automatic test_rsp_backpressure();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      rsp_hold_left <= HOLD_OFF_CYCLES;
      load_random_coeffs();
      send_conversion(OP_TEMP, rand_raw());
      for (int i = 0; i < 11; i++) begin
         send_conversion(($urandom_range(0, 3) == 0) ? OP_TEMP : OP_PRESS, rand_raw());
      end
      wait_drained();
   endtask

   // bursts of temperature-then-pressure sequences with some noise,
   // fresh coefficients between bursts
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
      int sent;
      int burst_end;
      int tail;
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
      sent = 0;
      while (sent < n_items) begin
         load_random_coeffs();
         burst_end = sent + $urandom_range(60, 120);
         while (sent < burst_end && sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
               send_conversion(OP_TEMP, rand_raw());
               tail = $urandom_range(1, 3);
               repeat (tail) send_conversion(OP_PRESS, rand_raw());
               sent += tail + 1;
            end else begin
               send_conversion(($urandom_range(0, 1) == 1) ? OP_PRESS : OP_TEMP,
                               RAW_W'($urandom()));
               sent++;
            end
         end
         wait_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      int waited;
      repeat (RESET_CYCLES) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 13;
      recv_idle_pct <= 68;

      test_pressure_before_temp();
      test_coeff_extremes();
      test_unused_index();
      test_rsp_backpressure();
      test_random_traffic(13, 68, 430);
      test_random_traffic(68, 13, 430);
      test_random_traffic(0, 0, 430);

      // final drain with its own limit, then anything left is a failure
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         failures++;
      end

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/bsc_pkg.sv
src/baro_sensor_compensation_top.sv
tb/baro_sensor_compensation_top_tb.sv
